@@ sv/nns_pkg.sv @@
`timescale 1ns / 1ps

package nns_pkg;

  // Default sizes
  localparam int POINT_DEPTH_DEF   = 1024;
  localparam int SEGMENT_DEPTH_DEF = 2048;
  localparam int COORD_BITS_DEF    = 20;

  // Fixed field widths
  localparam int KIND_W  = 2;
  localparam int PIN_W   = 10;
  localparam int MAXD_W  = 21;
  localparam int INDEX_W = 11;
  localparam int STAT_W  = 2;

  // Bits of the second operand taken per cycle by the wide multiplier
  localparam int MUL_DIGIT = 8;

  // Last step of the multiply sequence, for point and segment queries
  localparam logic [3:0] STEP_PT_LAST = 4'd2;
  localparam logic [3:0] STEP_SG_LAST = 4'd10;

  // Item kinds
  localparam logic [KIND_W-1:0] K_ADD_PT = 2'd0;
  localparam logic [KIND_W-1:0] K_ADD_SG = 2'd1;
  localparam logic [KIND_W-1:0] K_PT_Q   = 2'd2;
  localparam logic [KIND_W-1:0] K_SG_Q   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_TWIN,
    S_INIT,
    S_PT_RD,
    S_PT_WT,
    S_PT_CMP,
    S_SG_RD,
    S_SG_WT,
    S_PA,
    S_PB,
    S_MUL,
    S_SEL,
    S_CSQ,
    S_CSQ_W,
    S_LHS,
    S_LHS_W,
    S_RHS,
    S_RHS_W,
    S_FIN,
    S_DONE
  } state_t;

endpackage

@@ sv/nearest_node_and_segment_search.sv @@
`timescale 1ns / 1ps

// Nearest point and nearest segment search over stored 2-D points.
// Input channel (in_valid / in_stall) takes one item of four kinds: add a
// point, add a segment (optionally with its reversed twin), find the nearest
// point, find the nearest segment closer than in_max_distance. Every item
// gives exactly one result on the output channel (out_valid / out_stall):
// out_item_index and out_status.
// Work per item, from acceptance to result loaded:
//   add point and add segment write their table (a twin in its own state),
//   point query reads, multiplies and compares each stored point, and
//   skips the scan when the point table is empty,
//   segment query works per stored segment: segment and two point
//   reads from the tables, ten signed multiplies, then two or
//   three wide products of (NUM_W x RW) bits built 8 bits per cycle.
// One item is worked on at a time; in_stall is high until the result is in
// the output register. A result waiting under out_stall does not block the
// next item; the block only holds its next result until the register frees.
// Synchronous reset clears the point and segment counts; table contents are
// not cleared and are never read before they are written.

module nearest_node_and_segment_search #(
  parameter int POINT_DEPTH   = nns_pkg::POINT_DEPTH_DEF,
  parameter int SEGMENT_DEPTH = nns_pkg::SEGMENT_DEPTH_DEF,
  parameter int COORD_BITS    = nns_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nns_pkg::KIND_W-1:0]   in_kind,
  input  logic [COORD_BITS-1:0]        in_pos_x,
  input  logic [COORD_BITS-1:0]        in_pos_y,
  input  logic [nns_pkg::PIN_W-1:0]    in_from_point,
  input  logic [nns_pkg::PIN_W-1:0]    in_to_point,
  input  logic                         in_both_ways,
  input  logic [nns_pkg::MAXD_W-1:0]   in_max_distance,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nns_pkg::INDEX_W-1:0]  out_item_index,
  output logic [nns_pkg::STAT_W-1:0]   out_status
);

  localparam int CB    = COORD_BITS;
  localparam int D     = CB + 1;
  localparam int SW    = (D > nns_pkg::MAXD_W + 1) ? D : nns_pkg::MAXD_W + 1;
  localparam int RW    = 2 * SW + 1;
  localparam int NUM_W = 2 * RW;
  localparam int DIG   = nns_pkg::MUL_DIGIT;
  localparam int PW    = NUM_W + ((RW + DIG - 1) / DIG) * DIG;
  localparam int PIW   = $clog2(POINT_DEPTH);
  localparam int SIW   = $clog2(SEGMENT_DEPTH);
  localparam int PCW   = $clog2(POINT_DEPTH + 1);
  localparam int SCW   = $clog2(SEGMENT_DEPTH + 1);
  localparam int IW    = (PCW > SCW) ? PCW : SCW;
  localparam int CW    = (PCW > nns_pkg::PIN_W) ? PCW : nns_pkg::PIN_W;

  nns_pkg::state_t state_r, state_nxt;

  logic [PCW-1:0] pcount_r;
  logic [SCW-1:0] scount_r;

  logic [nns_pkg::KIND_W-1:0] kind_r;
  logic signed [CB-1:0]       px_r, py_r;
  logic [nns_pkg::PIN_W-1:0]  from_r, to_r;
  logic                       both_r;
  logic [nns_pkg::MAXD_W-1:0] maxd_r;

  logic [IW-1:0]        scan_r;
  logic [PIW-1:0]       b_idx_r;
  logic signed [CB-1:0] ax_r, ay_r;
  logic signed [D-1:0]  apx_r, apy_r, abx_r, aby_r, bpx_r, bpy_r;
  logic [3:0]           step_r;

  logic signed [SW-1:0]   mul_a, mul_b;
  logic signed [2*SW-1:0] prod_r, first_r;
  logic signed [RW-1:0]   l2_r, dot_r, ap_r, bp_r, cross_r;
  logic [RW-1:0]          cross_mag;

  logic [NUM_W-1:0] num_r, bnum_r;
  logic [RW-1:0]    den_r, bden_r;
  logic [PW-1:0]    lhs_r;
  logic [RW-1:0]    best_d_r;
  logic             found_r;
  logic [IW-1:0]    best_idx_r;

  logic [nns_pkg::INDEX_W-1:0] res_idx_r, out_idx_r;
  logic [nns_pkg::STAT_W-1:0]  res_st_r, out_st_r;
  logic                        out_valid_r;

  // Memory and multiplier hookup
  logic              pt_we;
  logic [PIW-1:0]    pt_raddr;
  logic [2*CB-1:0]   pt_rdata;
  logic signed [CB-1:0] rd_x, rd_y;
  logic              sg_we;
  logic [2*PIW-1:0]  sg_wdata, sg_rdata;
  logic              wm_start, wm_done;
  logic [NUM_W-1:0]  wm_a;
  logic [RW-1:0]     wm_b;
  logic [PW-1:0]     wm_p;

  // Decision flags
  logic       pfull, bad_pt, sfull, last_pt, last_sg, out_load;
  logic [3:0] step_last;
  logic [SCW:0] s_need;

  assign rd_x = pt_rdata[CB-1:0];
  assign rd_y = pt_rdata[2*CB-1:CB];

  assign pfull   = (pcount_r == PCW'(POINT_DEPTH));
  assign bad_pt  = (CW'(from_r) >= CW'(pcount_r)) || (CW'(to_r) >= CW'(pcount_r));
  assign s_need  = (SCW+1)'(scount_r) + (both_r ? (SCW+1)'(2) : (SCW+1)'(1));
  assign sfull   = (s_need > (SCW+1)'(SEGMENT_DEPTH));
  assign last_pt = ((scan_r + 1'b1) == IW'(pcount_r));
  assign last_sg = ((scan_r + 1'b1) == IW'(scount_r));
  assign out_load  = (state_r == nns_pkg::S_DONE) && (!out_valid_r || !out_stall);
  assign step_last = (kind_r == nns_pkg::K_SG_Q) ? nns_pkg::STEP_SG_LAST
                                                 : nns_pkg::STEP_PT_LAST;
  assign cross_mag = cross_r[RW-1] ? RW'(-cross_r) : RW'(cross_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nns_pkg::S_IDLE: begin
        if (in_valid) state_nxt = nns_pkg::S_EXEC;
      end
      nns_pkg::S_EXEC: begin
        case (kind_r)
          nns_pkg::K_ADD_PT: state_nxt = nns_pkg::S_DONE;
          nns_pkg::K_ADD_SG: begin
            if (!bad_pt && !sfull && both_r) state_nxt = nns_pkg::S_TWIN;
            else state_nxt = nns_pkg::S_DONE;
          end
          nns_pkg::K_PT_Q: begin
            if (pcount_r == '0) state_nxt = nns_pkg::S_DONE;
            else state_nxt = nns_pkg::S_PT_RD;
          end
          default: state_nxt = nns_pkg::S_INIT;
        endcase
      end
      nns_pkg::S_TWIN: state_nxt = nns_pkg::S_DONE;
      nns_pkg::S_INIT: begin
        if (scount_r == '0) state_nxt = nns_pkg::S_FIN;
        else state_nxt = nns_pkg::S_SG_RD;
      end
      nns_pkg::S_PT_RD: state_nxt = nns_pkg::S_PT_WT;
      nns_pkg::S_PT_WT: state_nxt = nns_pkg::S_MUL;
      nns_pkg::S_PT_CMP: begin
        if (last_pt) state_nxt = nns_pkg::S_FIN;
        else state_nxt = nns_pkg::S_PT_RD;
      end
      nns_pkg::S_SG_RD: state_nxt = nns_pkg::S_SG_WT;
      nns_pkg::S_SG_WT: state_nxt = nns_pkg::S_PA;
      nns_pkg::S_PA:    state_nxt = nns_pkg::S_PB;
      nns_pkg::S_PB:    state_nxt = nns_pkg::S_MUL;
      nns_pkg::S_MUL: begin
        if (step_r == step_last) begin
          if (kind_r == nns_pkg::K_SG_Q) state_nxt = nns_pkg::S_SEL;
          else state_nxt = nns_pkg::S_PT_CMP;
        end
      end
      nns_pkg::S_SEL: begin
        if (l2_r == '0 || dot_r[RW-1] || dot_r == '0 || dot_r >= l2_r) begin
          state_nxt = nns_pkg::S_LHS;
        end else begin
          state_nxt = nns_pkg::S_CSQ;
        end
      end
      nns_pkg::S_CSQ: state_nxt = nns_pkg::S_CSQ_W;
      nns_pkg::S_CSQ_W: begin
        if (wm_done) state_nxt = nns_pkg::S_LHS;
      end
      nns_pkg::S_LHS: state_nxt = nns_pkg::S_LHS_W;
      nns_pkg::S_LHS_W: begin
        if (wm_done) state_nxt = nns_pkg::S_RHS;
      end
      nns_pkg::S_RHS: state_nxt = nns_pkg::S_RHS_W;
      nns_pkg::S_RHS_W: begin
        if (wm_done) begin
          if (last_sg) state_nxt = nns_pkg::S_FIN;
          else state_nxt = nns_pkg::S_SG_RD;
        end
      end
      nns_pkg::S_FIN: state_nxt = nns_pkg::S_DONE;
      nns_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = nns_pkg::S_IDLE;
      end
      default: state_nxt = nns_pkg::S_IDLE;
    endcase
  end

  // Control outputs: memory strobes, multiplier operands
  always_comb begin
    in_stall = (state_r != nns_pkg::S_IDLE);
    pt_we    = 1'b0;
    sg_we    = 1'b0;
    sg_wdata = {PIW'(to_r), PIW'(from_r)};
    pt_raddr = '0;
    wm_start = 1'b0;
    wm_a     = num_r;
    wm_b     = bden_r;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      nns_pkg::S_EXEC: begin
        pt_we = (kind_r == nns_pkg::K_ADD_PT) && !pfull;
        sg_we = (kind_r == nns_pkg::K_ADD_SG) && !bad_pt && !sfull;
        mul_a = SW'($signed({1'b0, maxd_r}));
        mul_b = SW'($signed({1'b0, maxd_r}));
      end
      nns_pkg::S_TWIN: begin
        sg_we    = 1'b1;
        sg_wdata = {PIW'(from_r), PIW'(to_r)};
      end
      nns_pkg::S_PT_RD: pt_raddr = scan_r[PIW-1:0];
      nns_pkg::S_SG_WT: pt_raddr = sg_rdata[PIW-1:0];
      nns_pkg::S_PA:    pt_raddr = b_idx_r;
      nns_pkg::S_MUL: begin
        case (step_r)
          4'd0: begin mul_a = SW'(abx_r); mul_b = SW'(abx_r); end
          4'd1: begin mul_a = SW'(aby_r); mul_b = SW'(aby_r); end
          4'd2: begin mul_a = SW'(apx_r); mul_b = SW'(abx_r); end
          4'd3: begin mul_a = SW'(apy_r); mul_b = SW'(aby_r); end
          4'd4: begin mul_a = SW'(apx_r); mul_b = SW'(apx_r); end
          4'd5: begin mul_a = SW'(apy_r); mul_b = SW'(apy_r); end
          4'd6: begin mul_a = SW'(bpx_r); mul_b = SW'(bpx_r); end
          4'd7: begin mul_a = SW'(bpy_r); mul_b = SW'(bpy_r); end
          4'd8: begin mul_a = SW'(apx_r); mul_b = SW'(aby_r); end
          4'd9: begin mul_a = SW'(apy_r); mul_b = SW'(abx_r); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      nns_pkg::S_CSQ: begin
        wm_start = 1'b1;
        wm_a     = NUM_W'(cross_mag);
        wm_b     = cross_mag;
      end
      nns_pkg::S_LHS: begin
        wm_start = 1'b1;
        wm_a     = num_r;
        wm_b     = bden_r;
      end
      nns_pkg::S_RHS: begin
        wm_start = 1'b1;
        wm_a     = bnum_r;
        wm_b     = den_r;
      end
      default: begin
        pt_raddr = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nns_pkg::S_IDLE;
      pcount_r    <= '0;
      scount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pt_we) pcount_r <= pcount_r + 1'b1;
      if (sg_we) scount_r <= scount_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Signed multiplier, one product per cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      nns_pkg::S_IDLE: begin
        kind_r <= in_kind;
        px_r   <= in_pos_x;
        py_r   <= in_pos_y;
        from_r <= in_from_point;
        to_r   <= in_to_point;
        both_r <= in_both_ways;
        maxd_r <= in_max_distance;
      end
      nns_pkg::S_EXEC: begin
        found_r  <= 1'b0;
        scan_r   <= '0;
        res_idx_r <= '0;
        res_st_r  <= nns_pkg::ST_OK;
        case (kind_r)
          nns_pkg::K_ADD_PT: begin
            if (pfull) res_st_r <= nns_pkg::ST_FULL;
            else res_idx_r <= nns_pkg::INDEX_W'(pcount_r);
          end
          nns_pkg::K_ADD_SG: begin
            if (bad_pt) res_st_r <= nns_pkg::ST_BAD;
            else if (sfull) res_st_r <= nns_pkg::ST_FULL;
            else res_idx_r <= nns_pkg::INDEX_W'(scount_r);
          end
          nns_pkg::K_PT_Q: begin
            if (pcount_r == '0) res_st_r <= nns_pkg::ST_NONE;
          end
          default: begin
            res_st_r <= nns_pkg::ST_OK;
          end
        endcase
      end
      nns_pkg::S_INIT: begin
        bnum_r <= NUM_W'($unsigned(prod_r));
        bden_r <= RW'(1);
      end
      nns_pkg::S_PT_WT: begin
        abx_r  <= D'(rd_x) - D'(px_r);
        aby_r  <= D'(rd_y) - D'(py_r);
        step_r <= '0;
      end
      nns_pkg::S_PT_CMP: begin
        if (!found_r || $unsigned(l2_r) < best_d_r) begin
          best_d_r   <= $unsigned(l2_r);
          best_idx_r <= scan_r;
          found_r    <= 1'b1;
        end
        scan_r <= scan_r + 1'b1;
      end
      nns_pkg::S_SG_WT: begin
        b_idx_r <= sg_rdata[2*PIW-1:PIW];
      end
      nns_pkg::S_PA: begin
        ax_r <= rd_x;
        ay_r <= rd_y;
      end
      nns_pkg::S_PB: begin
        apx_r  <= D'(px_r) - D'(ax_r);
        apy_r  <= D'(py_r) - D'(ay_r);
        abx_r  <= D'(rd_x) - D'(ax_r);
        aby_r  <= D'(rd_y) - D'(ay_r);
        bpx_r  <= D'(px_r) - D'(rd_x);
        bpy_r  <= D'(py_r) - D'(rd_y);
        step_r <= '0;
      end
      nns_pkg::S_MUL: begin
        step_r <= step_r + 1'b1;
        // fold the product of the previous step into its pair sum, or pair difference at the last step
        case (step_r)
          4'd1, 4'd3, 4'd5, 4'd7, 4'd9: first_r <= prod_r;
          4'd2:  l2_r    <= RW'(first_r) + RW'(prod_r);
          4'd4:  dot_r   <= RW'(first_r) + RW'(prod_r);
          4'd6:  ap_r    <= RW'(first_r) + RW'(prod_r);
          4'd8:  bp_r    <= RW'(first_r) + RW'(prod_r);
          4'd10: cross_r <= RW'(first_r) - RW'(prod_r);
          default: first_r <= first_r;
        endcase
      end
      nns_pkg::S_SEL: begin
        den_r <= RW'(1);
        if (l2_r == '0 || dot_r[RW-1] || dot_r == '0) begin
          num_r <= NUM_W'($unsigned(ap_r));
        end else begin
          num_r <= NUM_W'($unsigned(bp_r));
        end
      end
      nns_pkg::S_CSQ_W: begin
        if (wm_done) begin
          num_r <= NUM_W'(wm_p);
          den_r <= $unsigned(l2_r);
        end
      end
      nns_pkg::S_LHS_W: begin
        if (wm_done) lhs_r <= wm_p;
      end
      nns_pkg::S_RHS_W: begin
        if (wm_done) begin
          if (lhs_r < wm_p) begin
            bnum_r     <= num_r;
            bden_r     <= den_r;
            best_idx_r <= scan_r;
            found_r    <= 1'b1;
          end
          scan_r <= scan_r + 1'b1;
        end
      end
      nns_pkg::S_FIN: begin
        res_st_r  <= found_r ? nns_pkg::ST_OK : nns_pkg::ST_NONE;
        res_idx_r <= found_r ? nns_pkg::INDEX_W'(best_idx_r) : '0;
      end
      nns_pkg::S_DONE: begin
        if (out_load) begin
          out_idx_r <= res_idx_r;
          out_st_r  <= res_st_r;
        end
      end
      default: begin
        step_r <= step_r;
      end
    endcase
  end

  // Point table: {y, x}
  nns_ram #(
    .W     (2 * CB),
    .DEPTH (POINT_DEPTH)
  ) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pcount_r[PIW-1:0]),
    .wdata ({py_r, px_r}),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // Segment table: {end, start}
  nns_ram #(
    .W     (2 * PIW),
    .DEPTH (SEGMENT_DEPTH)
  ) u_sg_ram (
    .clk   (clk),
    .we    (sg_we),
    .waddr (scount_r[SIW-1:0]),
    .wdata (sg_wdata),
    .raddr (scan_r[SIW-1:0]),
    .rdata (sg_rdata)
  );

  // Wide products for the exact distance compare
  nns_wmul #(
    .A_W (NUM_W),
    .B_W (RW)
  ) u_wmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wm_start),
    .a     (wm_a),
    .b     (wm_b),
    .done  (wm_done),
    .p     (wm_p)
  );

  assign out_valid      = out_valid_r;
  assign out_item_index = out_idx_r;
  assign out_status     = out_st_r;

`ifndef SYNTHESIS
  a_pcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcount_r <= PCW'(POINT_DEPTH))
    else $error("point count beyond table depth");

  a_scount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scount_r <= SCW'(SEGMENT_DEPTH))
    else $error("segment count beyond table depth");

  a_err_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == nns_pkg::ST_OK || out_item_index == '0))
    else $error("failed item carries a nonzero index");

  a_wmul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    wm_done |-> (state_r == nns_pkg::S_CSQ_W || state_r == nns_pkg::S_LHS_W ||
                 state_r == nns_pkg::S_RHS_W))
    else $error("wide product finished outside a wait state");
`endif

endmodule

@@ sv/nns_ram.sv @@
`timescale 1ns / 1ps

module nns_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/nns_wmul.sv @@
`timescale 1ns / 1ps

module nns_wmul #(
  parameter int A_W = 8,
  parameter int B_W = 8,
  localparam int DIG = nns_pkg::MUL_DIGIT,
  localparam int ND  = (B_W + DIG - 1) / DIG,
  localparam int PW  = A_W + ND * DIG
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           done,
  output logic [PW-1:0]  p
);

  localparam int CNTW = $clog2(ND + 1);
  localparam int PPW  = A_W + DIG;

  logic [PW-1:0]     acc_r;
  logic [A_W-1:0]    a_r;
  logic [ND*DIG-1:0] b_r;
  logic [CNTW-1:0]   cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [PPW-1:0]    pp;

  // Partial product of the held operand and the top digit
  assign pp = PPW'(a_r) * PPW'(b_r[ND*DIG-1 -: DIG]);

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(ND);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift-accumulate, most significant digit first
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= (ND*DIG)'(b);
    end else if (busy_r) begin
      acc_r <= (acc_r << DIG) + PW'(pp);
      b_r   <= b_r << DIG;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule
